[rtl/pid_controller_antiwindup_core_defines.svh]
// Assertion macros for the PID controller RTL.
`ifndef PID_CONTROLLER_ANTIWINDUP_CORE_DEFINES_SVH
`define PID_CONTROLLER_ANTIWINDUP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PIDAW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("pidaw check");
`define PIDAW_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("pidaw check");
`else
`define PIDAW_ASSERT(lbl, prop)
`define PIDAW_NEVER(lbl, expr)
`endif
`endif

[rtl/pidaw_pkg.sv]
// Types, constants and saturation helpers for the PID controller.
package pidaw_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MUL_WIDTH  = DATA_WIDTH + 2;
    localparam int MAG_WIDTH  = 2 * MUL_WIDTH + 1;
    localparam int QUO_WIDTH  = DATA_WIDTH + 1 + FRAC_BITS;
    localparam int IDX_WIDTH  = 3;

    localparam logic [IDX_WIDTH-1:0] REG_GAIN_PROP   = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_GAIN_INTEG  = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_GAIN_DERIV  = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_GUARD_ON    = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_DRIVE_FLOOR = 3'd4;
    localparam logic [IDX_WIDTH-1:0] REG_DRIVE_CEIL  = 3'd5;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] target;
        logic signed [DATA_WIDTH-1:0] measured;
        logic [DATA_WIDTH-2:0]        step_time;
    } pid_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] drive;
        logic                         clamped;
    } pid_out_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ERR, ST_EINT, ST_INC_GO, ST_INC_WAIT, ST_P_GO, ST_P_WAIT,
        ST_I_GO, ST_I_WAIT, ST_D_GO, ST_D_WAIT, ST_LIM, ST_OUT
    } pid_state_t;

    typedef enum logic [1:0] {
        OP_INC, OP_PROP, OP_INTEG, OP_DERIV
    } pid_op_t;

    function automatic logic signed [DATA_WIDTH-1:0] sat_w(
        input logic signed [DATA_WIDTH+1:0] v);
        logic signed [DATA_WIDTH+1:0] smax;
        logic signed [DATA_WIDTH+1:0] smin;
        smax = {3'b000, {(DATA_WIDTH-1){1'b1}}};
        smin = {3'b111, {(DATA_WIDTH-1){1'b0}}};
        if (v > smax)
            return smax[DATA_WIDTH-1:0];
        else if (v < smin)
            return smin[DATA_WIDTH-1:0];
        return v[DATA_WIDTH-1:0];
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_mag(
        input logic neg, input logic [MAG_WIDTH-1:0] m);
        logic [MAG_WIDTH-1:0] lim;
        logic [DATA_WIDTH-1:0] lo;
        lim = MAG_WIDTH'(1) << (DATA_WIDTH - 1);
        lo  = m[DATA_WIDTH-1:0];
        if (neg)
            return (m > lim) ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : -lo;
        return (m >= lim) ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : lo;
    endfunction

endpackage

[rtl/pidaw_mul.sv]
// Bit-serial signed multiplier with rounded fixed-point shift and saturation.
module pidaw_mul (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic signed [pidaw_pkg::MUL_WIDTH-1:0]      a,
    input  logic signed [pidaw_pkg::MUL_WIDTH-1:0]      b,
    input  logic                                        extra_shift,
    output logic                                        done,
    output logic signed [pidaw_pkg::DATA_WIDTH-1:0]     result
);
    localparam int MW = pidaw_pkg::MUL_WIDTH;
    localparam int FB = pidaw_pkg::FRAC_BITS;
    localparam int CW = $clog2(MW + 1);

    logic [MW-1:0]     mcand_reg;
    logic [MW-1:0]     mplier_reg;
    logic [2*MW-1:0]   acc_reg;
    logic              neg_reg;
    logic              shift_reg;
    logic              busy_reg;
    logic              fin_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic signed [pidaw_pkg::DATA_WIDTH-1:0] result_reg;

    logic [MW:0]       sum;
    logic [2*MW:0]     rnd;
    logic [2*MW:0]     shifted;

    assign sum = {1'b0, acc_reg[2*MW-1:MW]} + (mplier_reg[0] ? {1'b0, mcand_reg} : '0);
    assign rnd = {1'b0, acc_reg} + (shift_reg ? ((2*MW+1)'(1) << FB)
                                              : ((2*MW+1)'(1) << (FB - 1)));
    assign shifted = shift_reg ? (rnd >> (FB + 1)) : (rnd >> FB);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(MW - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= a[MW-1] ? MW'(-a) : MW'(a);
            mplier_reg <= b[MW-1] ? MW'(-b) : MW'(b);
            neg_reg    <= a[MW-1] ^ b[MW-1];
            shift_reg  <= extra_shift;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg    <= {sum, acc_reg[MW-1:1]};
            mplier_reg <= mplier_reg >> 1;
        end
        else if (fin_reg)
        begin
            result_reg <= pidaw_pkg::sat_mag(neg_reg, shifted);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
endmodule

[rtl/pidaw_div.sv]
// Bit-serial restoring divider for the fixed-point derivative quotient.
module pidaw_div (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic signed [pidaw_pkg::DATA_WIDTH:0]       num,
    input  logic [pidaw_pkg::DATA_WIDTH-2:0]            den,
    output logic                                        done,
    output logic signed [pidaw_pkg::DATA_WIDTH-1:0]     result
);
    localparam int W  = pidaw_pkg::DATA_WIDTH;
    localparam int NB = pidaw_pkg::QUO_WIDTH;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0]  dvd_reg;
    logic [NB-1:0]  quo_reg;
    logic [W-2:0]   rem_reg;
    logic [W-2:0]   den_reg;
    logic           neg_reg;
    logic           busy_reg;
    logic           fin_reg;
    logic           done_reg;
    logic [CW-1:0]  cnt_reg;
    logic signed [W-1:0] result_reg;

    logic [W-1:0]   r2;
    logic [W-1:0]   r2_sub;
    logic           ge;
    logic [W:0]     num_mag;

    assign r2      = {rem_reg, dvd_reg[NB-1]};
    assign r2_sub  = r2 - {1'b0, den_reg};
    assign ge      = r2 >= {1'b0, den_reg};
    assign num_mag = num[W] ? -num : num;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NB - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {num_mag, {pidaw_pkg::FRAC_BITS{1'b0}}};
            den_reg <= den;
            neg_reg <= num[W];
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= ge ? r2_sub[W-2:0] : r2[W-2:0];
            quo_reg <= {quo_reg[NB-2:0], ge};
        end
        else if (fin_reg)
        begin
            result_reg <= pidaw_pkg::sat_mag(neg_reg,
                                             pidaw_pkg::MAG_WIDTH'(quo_reg));
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
endmodule

[rtl/pid_controller_antiwindup_core.sv]
// Top level of the PID controller with back-calculation anti-windup.
//
//  channel  dir  handshake            word
//  in       in   in_valid/in_stall    target, measured, step_time
//  out      out  out_valid/out_stall  drive, clamped
//  cfg      in   cfg_we               cfg_index, cfg_data
//
// Each word runs four multiplies in turn on the shared serial multiplier, plus error,
// anti-windup, limit and load steps; the divider runs beside them. The next word can
// be taken once the result of the last one has been loaded into the output register.
// Reset clears the loop state and the registers to their defaults.
// A finished word waits in the output register; the next input word is taken
// meanwhile, and its result holds until the output register is free.
`include "pid_controller_antiwindup_core_defines.svh"
module pid_controller_antiwindup_core (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  pidaw_pkg::pid_in_t                        in_data,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output pidaw_pkg::pid_out_t                       out_data,
    input  logic                                      cfg_we,
    input  logic [pidaw_pkg::IDX_WIDTH-1:0]           cfg_index,
    input  logic [pidaw_pkg::DATA_WIDTH-1:0]          cfg_data
);
    localparam int W  = pidaw_pkg::DATA_WIDTH;
    localparam int MW = pidaw_pkg::MUL_WIDTH;

    pidaw_pkg::pid_state_t state_reg, state_next;
    pidaw_pkg::pid_op_t    op;
    pidaw_pkg::pid_out_t   out_reg;

    logic signed [W-1:0] gain_p_reg, gain_i_reg, gain_d_reg, floor_reg, ceil_reg;
    logic                guard_reg;
    logic signed [W-1:0] last_err_reg, integ_reg, raw_reg, lim_reg;
    logic signed [W-1:0] tgt_reg, meas_reg, err_reg, eint_reg, deriv_reg, acc_reg;
    logic signed [W:0]   diff_reg;
    logic [W-2:0]        dt_reg;
    logic                deriv_ok_reg;
    logic                out_valid_reg;

    logic                mul_start, div_start, in_take, out_load;
    logic signed [MW-1:0] mul_a, mul_b;
    logic                mul_done, div_done;
    logic signed [W-1:0] mul_res, div_res;
    logic signed [W-1:0] err_next, eint_next, raw_next;

    function automatic logic signed [W-1:0] raw_next_integ(
        input logic signed [W-1:0] x, input logic signed [W-1:0] y);
        return pidaw_pkg::sat_w({{2{x[W-1]}}, x} + {{2{y[W-1]}}, y});
    endfunction

    pidaw_mul u_mul (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (mul_start),
        .a           (mul_a),
        .b           (mul_b),
        .extra_shift (op == pidaw_pkg::OP_INC),
        .done        (mul_done),
        .result      (mul_res)
    );

    pidaw_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (diff_reg),
        .den    (dt_reg),
        .done   (div_done),
        .result (div_res)
    );

    assign in_take  = in_valid && !in_stall;
    assign out_load = (state_reg == pidaw_pkg::ST_OUT) && (!out_valid_reg || !out_stall);

    assign err_next  = pidaw_pkg::sat_w({{2{tgt_reg[W-1]}}, tgt_reg}
                                        - {{2{meas_reg[W-1]}}, meas_reg});
    assign eint_next = guard_reg
        ? pidaw_pkg::sat_w({{2{err_reg[W-1]}}, err_reg}
            + {{2{1'b0}}, 1'b0, {(W-1){1'b0}}}
            + MW'(pidaw_pkg::sat_w({{2{lim_reg[W-1]}}, lim_reg}
                                   - {{2{raw_reg[W-1]}}, raw_reg})))
        : err_reg;
    assign raw_next  = pidaw_pkg::sat_w({{2{acc_reg[W-1]}}, acc_reg}
                                        + {{2{mul_res[W-1]}}, mul_res});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pidaw_pkg::ST_IDLE:     if (in_valid) state_next = pidaw_pkg::ST_ERR;
            pidaw_pkg::ST_ERR:      state_next = pidaw_pkg::ST_EINT;
            pidaw_pkg::ST_EINT:     state_next = pidaw_pkg::ST_INC_GO;
            pidaw_pkg::ST_INC_GO:   state_next = pidaw_pkg::ST_INC_WAIT;
            pidaw_pkg::ST_INC_WAIT: if (mul_done) state_next = pidaw_pkg::ST_P_GO;
            pidaw_pkg::ST_P_GO:     state_next = pidaw_pkg::ST_P_WAIT;
            pidaw_pkg::ST_P_WAIT:   if (mul_done) state_next = pidaw_pkg::ST_I_GO;
            pidaw_pkg::ST_I_GO:     state_next = pidaw_pkg::ST_I_WAIT;
            pidaw_pkg::ST_I_WAIT:   if (mul_done) state_next = pidaw_pkg::ST_D_GO;
            pidaw_pkg::ST_D_GO:     if (deriv_ok_reg) state_next = pidaw_pkg::ST_D_WAIT;
            pidaw_pkg::ST_D_WAIT:   if (mul_done) state_next = pidaw_pkg::ST_LIM;
            pidaw_pkg::ST_LIM:      state_next = pidaw_pkg::ST_OUT;
            pidaw_pkg::ST_OUT:      if (out_load) state_next = pidaw_pkg::ST_IDLE;
            default:                state_next = pidaw_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        mul_start = 1'b0;
        div_start = 1'b0;
        op        = pidaw_pkg::OP_INC;
        unique case (state_reg)
            pidaw_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            pidaw_pkg::ST_INC_GO:
            begin
                mul_start = 1'b1;
                div_start = (dt_reg != '0);
            end
            pidaw_pkg::ST_P_GO:
            begin
                mul_start = 1'b1;
                op        = pidaw_pkg::OP_PROP;
            end
            pidaw_pkg::ST_I_GO:
            begin
                mul_start = 1'b1;
                op        = pidaw_pkg::OP_INTEG;
            end
            pidaw_pkg::ST_D_GO:
            begin
                mul_start = deriv_ok_reg;
                op        = pidaw_pkg::OP_DERIV;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        case (op)
            pidaw_pkg::OP_INC:
            begin
                mul_a = {{2{eint_reg[W-1]}}, eint_reg} + {{2{last_err_reg[W-1]}}, last_err_reg};
                mul_b = {3'b000, dt_reg};
            end
            pidaw_pkg::OP_PROP:
            begin
                mul_a = {{2{gain_p_reg[W-1]}}, gain_p_reg};
                mul_b = {{2{err_reg[W-1]}}, err_reg};
            end
            pidaw_pkg::OP_INTEG:
            begin
                mul_a = {{2{gain_i_reg[W-1]}}, gain_i_reg};
                mul_b = {{2{integ_reg[W-1]}}, integ_reg};
            end
            default:
            begin
                mul_a = {{2{gain_d_reg[W-1]}}, gain_d_reg};
                mul_b = {{2{deriv_reg[W-1]}}, deriv_reg};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pidaw_pkg::ST_IDLE;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            guard_reg     <= 1'b0;
            floor_reg     <= {1'b1, {(W-1){1'b0}}};
            ceil_reg      <= {1'b0, {(W-1){1'b1}}};
            last_err_reg  <= '0;
            integ_reg     <= '0;
            raw_reg       <= '0;
            lim_reg       <= '0;
            deriv_ok_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pidaw_pkg::REG_GAIN_PROP:   gain_p_reg <= cfg_data;
                    pidaw_pkg::REG_GAIN_INTEG:  gain_i_reg <= cfg_data;
                    pidaw_pkg::REG_GAIN_DERIV:  gain_d_reg <= cfg_data;
                    pidaw_pkg::REG_GUARD_ON:    guard_reg  <= cfg_data[0];
                    pidaw_pkg::REG_DRIVE_FLOOR: floor_reg  <= cfg_data;
                    pidaw_pkg::REG_DRIVE_CEIL:  ceil_reg   <= cfg_data;
                    default:                    guard_reg  <= guard_reg;
                endcase
            end
            if (state_reg == pidaw_pkg::ST_INC_GO)
                deriv_ok_reg <= (dt_reg == '0);
            else if (div_done)
                deriv_ok_reg <= 1'b1;
            if (state_reg == pidaw_pkg::ST_INC_WAIT && mul_done)
                integ_reg <= raw_next_integ(integ_reg, mul_res);
            if (state_reg == pidaw_pkg::ST_D_WAIT && mul_done)
            begin
                raw_reg      <= raw_next;
                last_err_reg <= err_reg;
            end
            if (state_reg == pidaw_pkg::ST_LIM && guard_reg)
            begin
                if (raw_reg > ceil_reg)
                    lim_reg <= ceil_reg;
                else if (raw_reg < floor_reg)
                    lim_reg <= floor_reg;
                else
                    lim_reg <= raw_reg;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            tgt_reg  <= in_data.target;
            meas_reg <= in_data.measured;
            dt_reg   <= in_data.step_time;
        end
        if (state_reg == pidaw_pkg::ST_ERR)
            err_reg <= err_next;
        if (state_reg == pidaw_pkg::ST_EINT)
        begin
            eint_reg <= eint_next;
            diff_reg <= {err_reg[W-1], err_reg} - {last_err_reg[W-1], last_err_reg};
        end
        if (state_reg == pidaw_pkg::ST_INC_GO)
            deriv_reg <= '0;
        else if (div_done)
            deriv_reg <= div_res;
        if (state_reg == pidaw_pkg::ST_P_WAIT && mul_done)
            acc_reg <= mul_res;
        if (state_reg == pidaw_pkg::ST_I_WAIT && mul_done)
            acc_reg <= raw_next;
        if (out_load)
        begin
            out_reg.clamped <= guard_reg && ((raw_reg > ceil_reg) || (raw_reg < floor_reg));
            if (!guard_reg)
                out_reg.drive <= raw_reg;
            else if (raw_reg > ceil_reg)
                out_reg.drive <= ceil_reg;
            else if (raw_reg < floor_reg)
                out_reg.drive <= floor_reg;
            else
                out_reg.drive <= raw_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `PIDAW_NEVER(a_take_only_idle, in_take && state_reg != pidaw_pkg::ST_IDLE)
    `PIDAW_NEVER(a_mul_start_busy, mul_start && state_reg == pidaw_pkg::ST_IDLE)
    `PIDAW_ASSERT(a_clamp_needs_guard, out_valid && out_data.clamped |-> guard_reg)
    `PIDAW_ASSERT(a_load_sets_valid, out_load |=> out_valid_reg)
endmodule

[test/tb_pid_controller_antiwindup_core.sv]
// PID controller core testbench: directed table plus random words, checked by table or predictor.
`timescale 1ns / 100ps
module tb_pid_controller_antiwindup_core;

    localparam longint DMAX = 64'sd2147483647;
    localparam longint DMIN = -64'sd2147483648;
    localparam longint ONE  = 64'sd65536;
    localparam logic [pidaw_pkg::IDX_WIDTH-1:0] REG_UNMAPPED = 3'd6;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_stall;
    pidaw_pkg::pid_in_t                   in_data;
    logic                                 out_valid;
    logic                                 out_stall;
    pidaw_pkg::pid_out_t                  out_data;
    logic                                 cfg_we;
    logic [pidaw_pkg::IDX_WIDTH-1:0]      cfg_index;
    logic [pidaw_pkg::DATA_WIDTH-1:0]     cfg_data;

    pid_controller_antiwindup_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of registers and loop state
    longint   kp, ki, kd, floor_v, ceil_v;
    bit       guard;
    longint   last_err, integ, raw_out, lim_out;

    pidaw_pkg::pid_out_t drive_q[$];
    int       errors;
    int       send_idle_pct;
    int       stall_pct;

    typedef struct {
        int          grp;
        longint      tgt;
        longint      meas;
        longint      dt;
        bit          typed;
        longint      drive;
        bit          clamped;
    } row_t;

    row_t stim_table[] = '{
        '{0, 0, 0, 0, 1, 0, 0},
        '{0, DMAX, DMIN, 64'h7fffffff, 1, 0, 0},
        '{0, DMIN, DMAX, 0, 1, 0, 0},
        '{0, DMIN, DMIN, 1, 1, 0, 0},
        '{0, -1, DMAX, 64'h40000000, 1, 0, 0},
        '{1, ONE, 0, ONE, 0, 0, 0},
        '{1, 3 * ONE, 0, 0, 0, 0, 0},
        '{1, DMAX, DMIN, 64'h7fffffff, 0, 0, 0},
        '{1, DMAX, DMIN, 1, 0, 0, 0},
        '{1, DMIN, DMAX, 64'h7fffffff, 0, 0, 0},
        '{1, -2 * ONE, ONE, ONE / 2, 0, 0, 0},
        '{1, 0, 0, 1, 0, 0, 0},
        '{2, ONE, 0, ONE, 0, 0, 0},
        '{2, -5 * ONE, 0, ONE, 0, 0, 0},
        '{2, 0, 0, ONE, 0, 0, 0},
        '{3, 7 * ONE, 0, ONE, 0, 0, 0},
        '{3, DMAX, DMIN, 3, 0, 0, 0},
        '{3, -1, 0, 0, 0, 0, 0},
        '{4, DMAX, DMIN, 64'h7fffffff, 0, 0, 0},
        '{4, DMIN, DMAX, 64'h7fffffff, 0, 0, 0},
        '{4, 12345, -6789, 1, 0, 0, 0}
    };

    function automatic longint sat_range(longint v);
        if (v > DMAX)
            return DMAX;
        if (v < DMIN)
            return DMIN;
        return v;
    endfunction

    function automatic longint sat_signed(bit neg, logic [127:0] m);
        if (neg)
            return (m > 128'd2147483648) ? DMIN : -longint'(m[63:0]);
        return (m > 128'd2147483647) ? DMAX : longint'(m[63:0]);
    endfunction

    function automatic longint mul_round(longint a, longint b, int sh);
        logic [127:0] m;
        longint       ua;
        longint       ub;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        m   = 128'(ua) * 128'(ub);
        m   = (m + (128'd1 << (sh - 1))) >> sh;
        return sat_signed(neg, m);
    endfunction

    function automatic longint div_rate(longint num, longint den);
        logic [127:0] m;
        longint       un;
        un = (num < 0) ? -num : num;
        m  = (128'(un) << pidaw_pkg::FRAC_BITS) / 128'(den);
        return sat_signed(num < 0, m);
    endfunction

    function automatic pidaw_pkg::pid_out_t pid_predict(pidaw_pkg::pid_in_t w);
        longint   err;
        longint   e_int;
        longint   deriv;
        longint   dt;
        pidaw_pkg::pid_out_t r;
        dt    = longint'(w.step_time);
        err   = sat_range(longint'(w.target) - longint'(w.measured));
        e_int = err;
        deriv = 0;
        if (guard)
            e_int = sat_range(err + sat_range(lim_out - raw_out));
        integ = sat_range(integ + mul_round(e_int + last_err, dt, pidaw_pkg::FRAC_BITS + 1));
        if (dt != 0)
            deriv = div_rate(err - last_err, dt);
        last_err = err;
        raw_out = sat_range(sat_range(mul_round(kp, err, pidaw_pkg::FRAC_BITS)
                  + mul_round(ki, integ, pidaw_pkg::FRAC_BITS))
                  + mul_round(kd, deriv, pidaw_pkg::FRAC_BITS));
        r.drive   = raw_out[31:0];
        r.clamped = 1'b0;
        if (guard)
        begin
            if (raw_out > ceil_v)
            begin
                lim_out   = ceil_v;
                r.clamped = 1'b1;
            end
            else if (raw_out < floor_v)
            begin
                lim_out   = floor_v;
                r.clamped = 1'b1;
            end
            else
                lim_out = raw_out;
            r.drive = lim_out[31:0];
        end
        return r;
    endfunction

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic write_reg(logic [pidaw_pkg::IDX_WIDTH-1:0] idx, longint val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[31:0];
        @(posedge clk);
        case (idx)
            pidaw_pkg::REG_GAIN_PROP:   kp      = longint'($signed(val[31:0]));
            pidaw_pkg::REG_GAIN_INTEG:  ki      = longint'($signed(val[31:0]));
            pidaw_pkg::REG_GAIN_DERIV:  kd      = longint'($signed(val[31:0]));
            pidaw_pkg::REG_GUARD_ON:    guard   = val[0];
            pidaw_pkg::REG_DRIVE_FLOOR: floor_v = longint'($signed(val[31:0]));
            pidaw_pkg::REG_DRIVE_CEIL:  ceil_v  = longint'($signed(val[31:0]));
            default: ;
        endcase
    endtask

    task automatic set_all(longint p, longint i, longint d, bit g, longint lo, longint hi);
        write_reg(pidaw_pkg::REG_GAIN_PROP, p);
        write_reg(pidaw_pkg::REG_GAIN_INTEG, i);
        write_reg(pidaw_pkg::REG_GAIN_DERIV, d);
        write_reg(pidaw_pkg::REG_GUARD_ON, longint'(g));
        write_reg(pidaw_pkg::REG_DRIVE_FLOOR, lo);
        write_reg(pidaw_pkg::REG_DRIVE_CEIL, hi);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (drive_q.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic send_word(pidaw_pkg::pid_in_t w, bit typed, pidaw_pkg::pid_out_t typed_res);
        pidaw_pkg::pid_out_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
        p = pid_predict(w);
        drive_q.push_back(typed ? typed_res : p);
    endtask

    function automatic longint rand_gain();
        case ($urandom_range(5))
            0: return DMIN;
            1: return DMAX;
            2: return longint'($signed($urandom));
            3: return 0;
            default: return longint'($urandom_range(2 * 65536)) - 65536;
        endcase
    endfunction

    function automatic longint rand_val();
        case ($urandom_range(3))
            0: return longint'($signed($urandom));
            default: return longint'($urandom_range(1 << 21)) - (1 << 20);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_q.size() == 0)
            begin
                $display("%0t: unexpected word drive=%0d clamped=%0b", $time,
                         out_data.drive, out_data.clamped);
                errors++;
            end
            else
            begin
                if (out_data.drive !== drive_q[0].drive)
                begin
                    $display("%0t: drive expected %0d actual %0d", $time,
                             drive_q[0].drive, out_data.drive);
                    errors++;
                end
                if (out_data.clamped !== drive_q[0].clamped)
                begin
                    $display("%0t: clamped expected %0b actual %0b", $time,
                             drive_q[0].clamped, out_data.clamped);
                    errors++;
                end
                void'(drive_q.pop_front());
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        pidaw_pkg::pid_in_t  w;
        pidaw_pkg::pid_out_t t;
        int       grp;
        longint   lo;
        longint   hi;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        errors    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        kp = 0; ki = 0; kd = 0; guard = 0; floor_v = DMIN; ceil_v = DMAX;
        last_err = 0; integ = 0; raw_out = 0; lim_out = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        grp = 0;
        foreach (stim_table[n])
        begin
            if (stim_table[n].grp != grp)
            begin
                grp = stim_table[n].grp;
                drain();
                case (grp)
                    1: set_all(ONE, ONE / 2, ONE / 4, 1'b1, -ONE, ONE);
                    2: set_all(2 * ONE, ONE, 0, 1'b1, 3 * ONE, -3 * ONE);
                    3: set_all(DMAX, DMIN, DMAX, 1'b0, 0, 0);
                    default:
                    begin
                        write_reg(REG_UNMAPPED, DMAX);
                        set_all(DMIN, DMAX, DMIN, 1'b1, DMIN, DMAX);
                    end
                endcase
            end
            w.target    = stim_table[n].tgt[31:0];
            w.measured  = stim_table[n].meas[31:0];
            w.step_time = stim_table[n].dt[30:0];
            t.drive     = stim_table[n].drive[31:0];
            t.clamped   = stim_table[n].clamped;
            send_word(w, stim_table[n].typed, t);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 47; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 47; end
                default: begin send_idle_pct = 10; stall_pct = 10; end
            endcase
            lo = rand_val();
            hi = rand_val();
            if (ph == 3)
            begin
                lo = DMAX;
                hi = DMIN;
            end
            set_all(rand_gain(), rand_gain(), rand_gain(), ph % 3 != 2, lo, hi);
            for (int k = 0; k < 125; k++)
            begin
                w.target   = rand_val();
                w.measured = rand_val();
                case ($urandom_range(9))
                    0: w.step_time = '0;
                    1: w.step_time = 31'($urandom);
                    default: w.step_time = 31'($urandom_range(1 << 17));
                endcase
                t = '0;
                send_word(w, 1'b0, t);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (drive_q.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[pid_controller_antiwindup_core.f]
+incdir+rtl
rtl/pidaw_pkg.sv
rtl/pidaw_mul.sv
rtl/pidaw_div.sv
rtl/pid_controller_antiwindup_core.sv
test/tb_pid_controller_antiwindup_core.sv
